// File: rtl/core/int_float_exact_compare_macros.svh
// Assertion macros used by the comparator top level.
`ifndef INT_FLOAT_EXACT_COMPARE_MACROS_SVH
`define INT_FLOAT_EXACT_COMPARE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define IFEC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IFEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/core/ifec_pkg.sv
// Package with the types and codes of the comparator.
package ifec_pkg;
   typedef enum logic [1:0] {
      FUNC_INT_LT = 2'd0,
      FUNC_INT_LE = 2'd1,
      FUNC_FLT_LT = 2'd2,
      FUNC_FLT_LE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ORD_LESS    = 2'd0,
      ORD_EQUAL   = 2'd1,
      ORD_GREATER = 2'd2,
      ORD_NONE    = 2'd3
   } ord_type;

   typedef struct packed {
      func_type    func;
      logic [63:0] int_value;
      logic [63:0] float_bits;
   } req_type;

   typedef struct packed {
      logic is_true;
   } rsp_type;
endpackage

// File: rtl/core/ifec_if.sv
// Valid/ready channel interfaces for requests and responses.
interface ifec_req_if import ifec_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ifec_rsp_if import ifec_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/ifec_order.sv
// Exact three-way ordering of a 64-bit integer against a binary64 float.
module ifec_order import ifec_pkg::*; (
   input  logic [63:0] int_value,
   input  logic [63:0] float_bits,
   output ord_type     ord
);
   logic        neg;
   logic [10:0] expo;
   logic [51:0] frac;
   logic [52:0] mant;
   logic [11:0] e2;   // effective exponent + 1075, i.e. max(expo,1)
   logic [63:0] ipart;
   logic        has_frac;
   logic [63:0] bi;
   logic [63:0] bp;
   logic        huge;
   logic [5:0]  sh_l;
   logic [6:0]  sh_r;
   logic [116:0] wide;

   always_comb begin
      neg   = float_bits[63];
      expo  = float_bits[62:52];
      frac  = float_bits[51:0];
      mant  = {(expo != 11'd0), frac};
      e2    = (expo != 11'd0) ? {1'b0, expo} : 12'd1;
      huge  = 1'b0;
      ipart = '0;
      has_frac = 1'b0;
      sh_l  = '0;
      sh_r  = '0;
      wide  = '0;
      // Magnitude at least 2^63 when e2 >= 1086.
      if (e2 >= 12'd1086) begin
         huge  = 1'b1;
         ipart = 64'h8000_0000_0000_0000;
      end else if (e2 >= 12'd1075) begin
         sh_l  = 6'(e2 - 12'd1075);
         ipart = {11'd0, mant} << sh_l;
      end else if (e2 <= 12'd1011) begin
         has_frac = (mant != 53'd0);
      end else begin
         // Right shift by 1..63: fraction bits land below bit 64.
         sh_r  = 7'(12'd1075 - e2);
         wide  = {mant, 64'd0} >> sh_r;
         ipart = {11'd0, wide[116:64]};
         has_frac = (wide[63:0] != 64'd0);
      end
      bi = int_value ^ 64'h8000_0000_0000_0000;
      bp = neg ? (64'h8000_0000_0000_0000 - ipart) : (64'h8000_0000_0000_0000 + ipart);

      if (expo == 11'h7FF) begin
         ord = (frac != 52'd0) ? ORD_NONE : (neg ? ORD_GREATER : ORD_LESS);
      end else if (huge && (!neg || e2 != 12'd1086 || frac != 52'd0)) begin
         ord = neg ? ORD_GREATER : ORD_LESS;
      end else if (bi < bp) begin
         ord = ORD_LESS;
      end else if (bi > bp) begin
         ord = ORD_GREATER;
      end else if (!has_frac) begin
         ord = ORD_EQUAL;
      end else begin
         ord = neg ? ORD_GREATER : ORD_LESS;
      end
   end
endmodule

// File: rtl/core/int_float_exact_compare.sv
// Top level of the exact integer versus double comparator.
//
//   channel  direction  payload
//   req      in         func, int_value, float_bits
//   rsp      out        is_true
//
// One item per cycle while the output is not stalled. An item waits in the input
// register, and the ordering logic and selector then load the result register.
// Reset (synchronous, active high) empties both registers. Each register stage
// holds its item while the stage after it is full and stalled.
`include "int_float_exact_compare_macros.svh"
module int_float_exact_compare import ifec_pkg::*; (
   input logic clock,
   input logic reset,
   ifec_req_if.sink   req,
   ifec_rsp_if.source rsp
);
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    in_adv, out_load;
   ord_type ord;
   logic    result;

   // The result register takes a new item when empty or being drained.
   assign out_load = in_valid_ff && (!out_valid_ff || rsp.ready);
   // The input register takes an item when empty or its item moves on.
   assign in_adv   = !in_valid_ff || out_load;
   assign req.ready = in_adv;

   ifec_order u_order (
      .int_value  (in_data_ff.int_value),
      .float_bits (in_data_ff.float_bits),
      .ord        (ord)
   );

   // A NaN answers false for every selector.
   always_comb begin
      case (in_data_ff.func)
         FUNC_INT_LT: result = (ord == ORD_LESS);
         FUNC_INT_LE: result = (ord == ORD_LESS) || (ord == ORD_EQUAL);
         FUNC_FLT_LT: result = (ord == ORD_GREATER);
         FUNC_FLT_LE: result = (ord == ORD_GREATER) || (ord == ORD_EQUAL);
         default:     result = 1'b0;
      endcase
   end

   always_comb begin
      in_valid_in  = in_adv ? req.valid : in_valid_ff;
      in_data_in   = (in_adv && req.valid) ? req.payload : in_data_ff;
      out_valid_in = out_load ? 1'b1 : (out_valid_ff && !rsp.ready);
      out_data_in  = out_load ? rsp_type'(result) : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_data_ff;

   // A held item in the input stage must move on once the output drains.
   `IFEC_ASSERT_NEXT(a_in_moves, clock, reset, in_valid_ff && rsp.ready, out_valid_ff)
   // A stalled result stays in place.
   `IFEC_ASSERT_NEXT(a_out_hold, clock, reset, out_valid_ff && !rsp.ready, out_valid_ff && $stable(out_data_ff))
   // A NaN float never produces a true result.
   `IFEC_ASSERT_NEXT(a_nan_false, clock, reset, out_load && ord == ORD_NONE, !out_data_ff.is_true)
endmodule
